@@ sv/stxrx_pkg.sv @@
// Shared types, codes and constants for the start/end code frame receiver.
package stxrx_pkg;

    localparam int ByteW  = 8;
    localparam int MaskW  = 10;
    localparam int StateW = 2;
    localparam int MatchW = 2;
    localparam int IndexW = 4;
    localparam int DataW  = 32;
    localparam int AddrW  = 4;

    // Receive state codes.
    localparam logic [StateW-1:0] ST_IDLE    = 2'd0;
    localparam logic [StateW-1:0] ST_BUSY    = 2'd1;
    localparam logic [StateW-1:0] ST_PENDING = 2'd2;

    // Progress through the "Dbg" prefix.
    localparam logic [MatchW-1:0] MATCH_NONE = 2'd0;
    localparam logic [MatchW-1:0] MATCH_D    = 2'd1;
    localparam logic [MatchW-1:0] MATCH_DB   = 2'd2;
    localparam logic [MatchW-1:0] MATCH_DBG  = 2'd3;

    // Register indexes (byte address is 4 times the index).
    localparam logic [1:0] REG_START_CODE = 2'd0;
    localparam logic [1:0] REG_END_CODE   = 2'd1;
    localparam logic [1:0] REG_DEBUG_MASK = 2'd2;

    localparam logic [ByteW-1:0] START_CODE_RESET = 8'h02;
    localparam logic [ByteW-1:0] END_CODE_RESET   = 8'h03;
    localparam logic [MaskW-1:0] DEBUG_MASK_RESET = '0;

    localparam logic [ByteW-1:0] CHAR_D    = 8'h44;
    localparam logic [ByteW-1:0] CHAR_B    = 8'h62;
    localparam logic [ByteW-1:0] CHAR_G    = 8'h67;
    localparam logic [ByteW-1:0] CHAR_ZERO = 8'h30;
    localparam logic [ByteW-1:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic [ByteW-1:0] start_code;
        logic [ByteW-1:0] end_code;
        logic [MaskW-1:0] debug_mask;
    } cfg_t;

    typedef struct packed {
        logic              payload_valid;
        logic [ByteW-1:0]  payload_byte;
        logic              frame_begin;
        logic              frame_done;
        logic              framing_error;
        logic [StateW-1:0] receive_state;
        logic              debug_fire;
        logic [IndexW-1:0] debug_index;
    } result_t;

endpackage

@@ sv/stxrx_cfg.sv @@
// APB register file holding the start code, end code and debug enable mask.
module stxrx_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stxrx_pkg::AddrW-1:0]   paddr,
    input  logic [stxrx_pkg::DataW-1:0]   pwdata,
    output logic [stxrx_pkg::DataW-1:0]   prdata,
    output logic                          pready,
    output stxrx_pkg::cfg_t               cfg
);

    stxrx_pkg::cfg_t cfg_reg;
    stxrx_pkg::cfg_t cfg_next;
    logic            wr_en;
    logic [1:0]      reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_index)
                stxrx_pkg::REG_START_CODE:
                    cfg_next.start_code = pwdata[stxrx_pkg::ByteW-1:0];
                stxrx_pkg::REG_END_CODE:
                    cfg_next.end_code = pwdata[stxrx_pkg::ByteW-1:0];
                stxrx_pkg::REG_DEBUG_MASK:
                    cfg_next.debug_mask = pwdata[stxrx_pkg::MaskW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code <= stxrx_pkg::START_CODE_RESET;
            cfg_reg.end_code   <= stxrx_pkg::END_CODE_RESET;
            cfg_reg.debug_mask <= stxrx_pkg::DEBUG_MASK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            stxrx_pkg::REG_START_CODE:
                prdata[stxrx_pkg::ByteW-1:0] = cfg_reg.start_code;
            stxrx_pkg::REG_END_CODE:
                prdata[stxrx_pkg::ByteW-1:0] = cfg_reg.end_code;
            stxrx_pkg::REG_DEBUG_MASK:
                prdata[stxrx_pkg::MaskW-1:0] = cfg_reg.debug_mask;
            default: prdata = '0;
        endcase
    end

endmodule

@@ sv/stxrx_step.sv @@
// Per-byte next-state and result logic of the deframer and debug trigger matcher.
module stxrx_step (
    input  logic [stxrx_pkg::ByteW-1:0]  rx_byte,
    input  stxrx_pkg::cfg_t              cfg,
    input  logic [stxrx_pkg::StateW-1:0] frame_state,
    input  logic [stxrx_pkg::MatchW-1:0] match_state,
    output logic [stxrx_pkg::StateW-1:0] frame_state_next,
    output logic [stxrx_pkg::MatchW-1:0] match_state_next,
    output stxrx_pkg::result_t           result
);

    logic                         is_digit;
    logic [stxrx_pkg::IndexW-1:0] digit;

    // '0'..'9' occupy 0x30..0x39, so the low nibble is the digit value.
    assign is_digit = (rx_byte >= stxrx_pkg::CHAR_ZERO) && (rx_byte <= stxrx_pkg::CHAR_NINE);
    assign digit    = rx_byte[stxrx_pkg::IndexW-1:0];

    always_comb begin
        result           = '0;
        frame_state_next = frame_state;
        match_state_next = stxrx_pkg::MATCH_NONE;

        // A start code wins over an end code when both are the same value.
        priority if (rx_byte == cfg.start_code) begin
            if (frame_state == stxrx_pkg::ST_IDLE) begin
                result.frame_begin = 1'b1;
                frame_state_next   = stxrx_pkg::ST_BUSY;
            end else begin
                result.framing_error = 1'b1;
                frame_state_next     = stxrx_pkg::ST_IDLE;
            end
        end else if (rx_byte == cfg.end_code) begin
            if (frame_state == stxrx_pkg::ST_BUSY) begin
                result.frame_done = 1'b1;
                frame_state_next  = stxrx_pkg::ST_PENDING;
            end else begin
                result.framing_error = 1'b1;
                frame_state_next     = stxrx_pkg::ST_IDLE;
            end
        end else if (frame_state == stxrx_pkg::ST_BUSY) begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
        end else begin
            // An ordinary byte while idle or pending leaves the frame state alone.
        end

        // Trigger matching only runs while the line is idle after the update.
        if (frame_state_next == stxrx_pkg::ST_IDLE) begin
            unique case (match_state)
                stxrx_pkg::MATCH_NONE:
                    match_state_next = (rx_byte == stxrx_pkg::CHAR_D) ?
                                       stxrx_pkg::MATCH_D : stxrx_pkg::MATCH_NONE;
                stxrx_pkg::MATCH_D:
                    match_state_next = (rx_byte == stxrx_pkg::CHAR_B) ?
                                       stxrx_pkg::MATCH_DB : stxrx_pkg::MATCH_NONE;
                stxrx_pkg::MATCH_DB:
                    match_state_next = (rx_byte == stxrx_pkg::CHAR_G) ?
                                       stxrx_pkg::MATCH_DBG : stxrx_pkg::MATCH_NONE;
                stxrx_pkg::MATCH_DBG: begin
                    if (is_digit && cfg.debug_mask[digit]) begin
                        result.debug_fire  = 1'b1;
                        result.debug_index = digit;
                    end
                    match_state_next = stxrx_pkg::MATCH_NONE;
                end
            endcase
        end

        result.receive_state = frame_state_next;
    end

endmodule

@@ sv/stx_etx_frame_receiver_core.sv @@
// Top level of the start/end code frame receiver with debug trigger detection.
//
// The block takes one received serial byte per transfer on the s_ channel
// (s_valid, s_ready, s_rx_byte) and returns exactly one result per byte on
// the m_ channel: payload flag and byte, frame begin, frame done, framing
// error, the receive state after the byte, and a debug trigger fire with
// its index.
// A byte is captured in an input register, decoded by a short block of
// logic against the frame and trigger state, and lands in an output
// register, from which the result is offered. Throughput is one byte per
// cycle while m_ready stays high, since the state update between the two
// registers is combinational.
// When the consumer holds m_ready low the result stays in the output
// register and one more byte can still be taken into the input register;
// after that s_ready drops until the output drains.
// Reset clears both pipeline valid flags, returns the frame state to idle
// and the trigger matcher to its start, and loads the register defaults:
// start code 0x02, end code 0x03, all debug triggers disabled.
// The APB port (byte addresses 0x0, 0x4, 0x8) must only be written while
// no byte is in flight.
module stx_etx_frame_receiver_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [stxrx_pkg::ByteW-1:0]   s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_payload_valid,
    output logic [stxrx_pkg::ByteW-1:0]   m_payload_byte,
    output logic                          m_frame_begin,
    output logic                          m_frame_done,
    output logic                          m_framing_error,
    output logic [stxrx_pkg::StateW-1:0]  m_receive_state,
    output logic                          m_debug_fire,
    output logic [stxrx_pkg::IndexW-1:0]  m_debug_index,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stxrx_pkg::AddrW-1:0]   paddr,
    input  logic [stxrx_pkg::DataW-1:0]   pwdata,
    output logic [stxrx_pkg::DataW-1:0]   prdata,
    output logic                          pready
);

    stxrx_pkg::cfg_t              cfg;
    stxrx_pkg::result_t           step_result;
    stxrx_pkg::result_t           result_reg;
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [stxrx_pkg::ByteW-1:0]  in_byte_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [stxrx_pkg::StateW-1:0] frame_state_reg;
    logic [stxrx_pkg::StateW-1:0] frame_state_next;
    logic [stxrx_pkg::MatchW-1:0] match_state_reg;
    logic [stxrx_pkg::MatchW-1:0] match_state_next;
    logic                         advance;
    logic                         in_take;
    logic                         step_fire;

    stxrx_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stxrx_step u_step (
        .rx_byte          (in_byte_reg),
        .cfg              (cfg),
        .frame_state      (frame_state_reg),
        .match_state      (match_state_reg),
        .frame_state_next (frame_state_next),
        .match_state_next (match_state_next),
        .result           (step_result)
    );

    // The output register can take a new result when it is empty or being drained.
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign in_take   = s_valid && s_ready;
    // A byte leaves the input register and commits its state update.
    assign step_fire = in_valid_reg && advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            frame_state_reg <= stxrx_pkg::ST_IDLE;
            match_state_reg <= stxrx_pkg::MATCH_NONE;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire) begin
                frame_state_reg <= frame_state_next;
                match_state_reg <= match_state_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step_fire) begin
            result_reg <= step_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_payload_valid = result_reg.payload_valid;
    assign m_payload_byte  = result_reg.payload_byte;
    assign m_frame_begin   = result_reg.frame_begin;
    assign m_frame_done    = result_reg.frame_done;
    assign m_framing_error = result_reg.framing_error;
    assign m_receive_state = result_reg.receive_state;
    assign m_debug_fire    = result_reg.debug_fire;
    assign m_debug_index   = result_reg.debug_index;

endmodule

@@ sv/stxrx_checker.sv @@
// Port-level checker for the frame receiver, bound to its top level.
module stxrx_port_asserts (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_payload_valid,
    input logic [stxrx_pkg::ByteW-1:0]   m_payload_byte,
    input logic                          m_frame_begin,
    input logic                          m_frame_done,
    input logic                          m_framing_error,
    input logic [stxrx_pkg::StateW-1:0]  m_receive_state,
    input logic                          m_debug_fire,
    input logic [stxrx_pkg::IndexW-1:0]  m_debug_index
);

    // A stalled result keeps its payload byte, receive state and debug index.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte)
            && $stable(m_receive_state) && $stable(m_debug_index))
        else $error("result changed while stalled");

    // At most one framing event per byte.
    a_event_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_frame_begin, m_frame_done, m_framing_error, m_payload_valid}))
        else $error("more than one framing event in a result");

    // Payload only comes out inside an open frame.
    a_payload_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_valid |-> m_receive_state == stxrx_pkg::ST_BUSY)
        else $error("payload outside busy state");

    // A completed frame leaves the receiver pending.
    a_done_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_receive_state == stxrx_pkg::ST_PENDING)
        else $error("frame done without pending state");

    // Debug triggers fire only while idle and only with a decimal index.
    a_fire_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_debug_fire |-> m_receive_state == stxrx_pkg::ST_IDLE
            && m_debug_index <= 4'd9)
        else $error("debug trigger fired outside idle or with bad index");

endmodule

bind stx_etx_frame_receiver_core stxrx_port_asserts u_stxrx_port_asserts (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_payload_valid (m_payload_valid),
    .m_payload_byte  (m_payload_byte),
    .m_frame_begin   (m_frame_begin),
    .m_frame_done    (m_frame_done),
    .m_framing_error (m_framing_error),
    .m_receive_state (m_receive_state),
    .m_debug_fire    (m_debug_fire),
    .m_debug_index   (m_debug_index)
);
